>>> hw/rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared constants, types and sequencer states for the alignment identity
// block.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int RES_W      = 8;
  localparam int CNT_W      = 16;
  localparam int THR_W      = 7;
  localparam int FRAC_W     = 17;
  localparam int SUM_W      = CNT_W + 1;
  localparam int PROD_W     = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [RES_W-1:0]  GAP_RESIDUE    = 8'h2D;
  localparam logic [CNT_W-1:0]  MAX_LENGTH     = 16'hFFFF;
  localparam int                CHECK_SHIFT    = 6;
  localparam logic [CNT_W-1:0]  CHECK_INTERVAL = 16'd64;
  localparam logic [PROD_W-1:0] PCT_SCALE      = 24'd100;
  localparam logic [CNT_W-1:0]  SEQ_LEN_RESET  = 16'd1;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_MUL,
    ST_CHK_CMP,
    ST_EMIT_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic set_early;
  } tally_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] valid_cnt;
    logic [CNT_W-1:0] match_cnt;
    logic             finished_early;
  } tally_stat_t;

endpackage

>>> hw/rtl/pairwise_alignment_identity.sv
// ----------------------------------------------------------------------------
// pairwise_alignment_identity
// Percent identity of a gapped residue pair stream with early stop.
//
//   Channel  Direction  Request content
//   in_      slave      residue pair, tlast closes the pair
//   out_     master     Q1.16 identity, threshold and early-stop flags
//   cfg_     slave      register index and write data
//
// A position due for the early-stop check passes through the shared percent
// unit in ST_CHK_MUL and ST_CHK_CMP. A result loads the operands, runs the
// divider for its 17 bit-serial steps, and moves into the output register.
// Synchronous reset sets the counters, config registers, state and output valid.
// A stalled result holds in the output register; the next pair starts
// counting as soon as the sequencer returns to idle.
// ----------------------------------------------------------------------------
module pairwise_alignment_identity (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // residue_a[7:0], residue_b[15:8]
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // identity_frac[16:0], zero pad
  output logic [1:0]                      out_tuser,  // above_threshold[0], stopped_early[1]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aip_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aip_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import aip_pkg::*;

  state_t            state_r, state_nxt;
  tally_cmd_t        cmd;
  tally_stat_t       stat;
  logic              check_req;
  logic              accept;
  logic              out_load;
  logic              mc_load;
  logic              mc_less;
  logic              mc_greater;
  logic              div_start;
  logic              div_busy;
  logic [FRAC_W-1:0] quot;
  logic [SUM_W-1:0]  op_x;
  logic [SUM_W-1:0]  op_y;
  logic [CNT_W-1:0]  rem;

  logic [THR_W-1:0]  thr_r;
  logic [CNT_W-1:0]  seq_len_r;
  logic [CNT_W-1:0]  idx_r;
  logic              last_r;
  logic              early_r;
  logic              above_r;
  logic              out_valid_r;
  logic [FRAC_W-1:0] out_frac_r;
  logic              out_above_r;
  logic              out_early_r;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= '0;
      seq_len_r <= SEQ_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r     <= cfg_data[THR_W-1:0];
        REG_SEQ_LEN:   seq_len_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  aip_tally u_tally (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .residue_a_i (in_tdata[7:0]),
    .residue_b_i (in_tdata[15:8]),
    .last_i      (in_tlast),
    .threshold_i (thr_r),
    .stat_o      (stat),
    .check_req_o (check_req)
  );

  assign rem = (seq_len_r > idx_r) ? (seq_len_r - idx_r) : '0;

  always_comb begin
    if (state_r == ST_CHK_MUL) begin
      op_x = SUM_W'(stat.match_cnt) + SUM_W'(rem);
      op_y = SUM_W'(stat.valid_cnt) + SUM_W'(rem);
    end else begin
      op_x = SUM_W'(stat.match_cnt);
      op_y = SUM_W'(stat.valid_cnt);
    end
  end

  aip_mulcmp u_mulcmp (
    .clk         (clk),
    .load_i      (mc_load),
    .x_i         (op_x),
    .y_i         (op_y),
    .threshold_i (thr_r),
    .less_o      (mc_less),
    .greater_o   (mc_greater)
  );

  aip_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (stat.match_cnt),
    .den_i   (stat.valid_cnt),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (check_req) begin
            state_nxt = ST_CHK_MUL;
          end else if (!stat.finished_early && in_tlast) begin
            state_nxt = ST_EMIT_MUL;
          end
        end
      end
      ST_CHK_MUL: state_nxt = ST_CHK_CMP;
      ST_CHK_CMP: state_nxt = (mc_less || last_r) ? ST_EMIT_MUL : ST_IDLE;
      ST_EMIT_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load      = (state_r == ST_OUT) && (!out_valid_r || out_tready);
    mc_load       = (state_r == ST_CHK_MUL) || (state_r == ST_EMIT_MUL);
    div_start     = (state_r == ST_EMIT_MUL);
    cmd.accept    = accept;
    cmd.clear     = out_load && last_r;
    cmd.set_early = out_load && early_r && !last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      early_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        last_r  <= in_tlast;
        early_r <= 1'b0;
      end else if (state_r == ST_CHK_CMP) begin
        early_r <= mc_less;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= stat.position;
    end
    if (state_r == ST_DIV) begin
      above_r <= mc_greater;
    end
    if (out_load) begin
      out_frac_r  <= (stat.valid_cnt == '0) ? '0 : quot;
      out_above_r <= above_r;
      out_early_r <= early_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_frac_r};
  assign out_tuser  = {out_early_r, out_above_r};

endmodule

>>> hw/rtl/aip_tally.sv
// ----------------------------------------------------------------------------
// aip_tally
// Position, valid and match counters of the current pair, plus the
// early-stop flag and the decision whether a position needs a check.
// ----------------------------------------------------------------------------
module aip_tally (
  input  logic                        clk,
  input  logic                        rst_n,
  input  aip_pkg::tally_cmd_t         cmd_i,
  input  logic [aip_pkg::RES_W-1:0]   residue_a_i,
  input  logic [aip_pkg::RES_W-1:0]   residue_b_i,
  input  logic                        last_i,
  input  logic [aip_pkg::THR_W-1:0]   threshold_i,
  output aip_pkg::tally_stat_t        stat_o,
  output logic                        check_req_o
);
  import aip_pkg::*;

  tally_stat_t stat_r, stat_nxt;
  logic        pos_valid;

  assign pos_valid = (residue_a_i != GAP_RESIDUE) && (residue_b_i != GAP_RESIDUE) &&
                     (stat_r.valid_cnt < MAX_LENGTH);

  assign check_req_o = !stat_r.finished_early && pos_valid && (threshold_i != '0) &&
                       (stat_r.position > CHECK_INTERVAL) &&
                       (stat_r.position[CHECK_SHIFT-1:0] == '0);

  always_comb begin
    stat_nxt = stat_r;
    if (cmd_i.clear) begin
      stat_nxt = '0;
    end else if (cmd_i.set_early) begin
      stat_nxt.finished_early = 1'b1;
    end else if (cmd_i.accept) begin
      if (stat_r.finished_early) begin
        if (last_i) begin
          stat_nxt = '0;
        end
      end else begin
        if (pos_valid) begin
          stat_nxt.valid_cnt = stat_r.valid_cnt + 1'b1;
          if (residue_a_i == residue_b_i) begin
            stat_nxt.match_cnt = stat_r.match_cnt + 1'b1;
          end
        end
        if (stat_r.position < MAX_LENGTH) begin
          stat_nxt.position = stat_r.position + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '0;
    end else begin
      stat_r <= stat_nxt;
    end
  end

  assign stat_o = stat_r;

endmodule

>>> hw/rtl/aip_mulcmp.sv
// ----------------------------------------------------------------------------
// aip_mulcmp
// Shared percent unit: registers x*100 and threshold*y, then compares them.
// Used for both the early-stop bound and the final threshold flag.
// ----------------------------------------------------------------------------
module aip_mulcmp (
  input  logic                        clk,
  input  logic                        load_i,
  input  logic [aip_pkg::SUM_W-1:0]   x_i,
  input  logic [aip_pkg::SUM_W-1:0]   y_i,
  input  logic [aip_pkg::THR_W-1:0]   threshold_i,
  output logic                        less_o,
  output logic                        greater_o
);
  import aip_pkg::*;

  logic [PROD_W-1:0] px_r, px_nxt;
  logic [PROD_W-1:0] py_r, py_nxt;

  always_comb begin
    px_nxt = px_r;
    py_nxt = py_r;
    if (load_i) begin
      px_nxt = PROD_W'(x_i) * PCT_SCALE;
      py_nxt = PROD_W'(threshold_i) * PROD_W'(y_i);
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    py_r <= py_nxt;
  end

  assign less_o    = px_r < py_r;
  assign greater_o = px_r > py_r;

endmodule

>>> hw/rtl/aip_divider.sv
// ----------------------------------------------------------------------------
// aip_divider
// Restoring divider giving floor(num * 65536 / den), one quotient bit per
// cycle. The numerator never exceeds the denominator, so 17 bits suffice.
// ----------------------------------------------------------------------------
module aip_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [aip_pkg::CNT_W-1:0]    num_i,
  input  logic [aip_pkg::CNT_W-1:0]    den_i,
  output logic                         busy_o,
  output logic [aip_pkg::FRAC_W-1:0]   quot_o
);
  import aip_pkg::*;

  localparam logic [4:0] DIV_STEPS = 5'(FRAC_W);

  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [FRAC_W-1:0] quot_r, quot_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, num_r[CNT_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start_i) begin
      rem_nxt  = {1'b0, num_i[CNT_W-1:1]};
      num_nxt  = {num_i[0], {(CNT_W-1){1'b0}}};
      den_nxt  = den_i;
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      num_nxt  = {num_r[CNT_W-2:0], 1'b0};
      quot_nxt = {quot_r[FRAC_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign busy_o = busy_r;
  assign quot_o = quot_r;

endmodule

>>> hw/rtl/aip_checker.sv
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks of the alignment identity block, bound to the top level.
// ----------------------------------------------------------------------------
module aip_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [23:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:17] == 7'd0) &&
                   (!out_tdata[16] || (out_tdata[15:0] == 16'd0)))
    else $error("Identity fraction above 1.0.");

  a_early_not_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("Early stop reported identity above threshold.");

  a_no_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && in_tready && !in_tvalid |=> !out_tvalid)
    else $error("Result appeared without a pending request.");

endmodule

bind pairwise_alignment_identity aip_checker u_aip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
